// ----- design/mma_pkg.sv -----
// Package for the multicanonical Metropolis acceptance block.
// Holds the item types, command and register codes and the fixed-point constants.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package mma_pkg;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [9:0]         table_index;
      logic signed [31:0] load_value;
      logic signed [31:0] charge_delta;
      logic [23:0]        uniform_fraction;
   } req_type;

   typedef struct packed {
      logic               accepted;
      logic signed [31:0] charge_now;
      logic signed [31:0] potential_change;
      logic [24:0]        accept_probability;
   } rsp_type;

   localparam logic [1:0] CMD_WRITE   = 2'd0;
   localparam logic [1:0] CMD_CHARGE  = 2'd1;
   localparam logic [1:0] CMD_PROPOSE = 2'd2;

   localparam logic [1:0] CSR_HALF_RANGE = 2'd0;
   localparam logic [1:0] CSR_SPACING    = 2'd1;
   localparam logic [1:0] CSR_POINTS     = 2'd2;

   localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
   localparam logic [30:0] ONE_Q30   = 31'd1073741824;
   localparam logic [24:0] ONE_Q24   = 25'd16777216;

   function automatic logic [63:0] isqrt64(input logic [63:0] value);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bitv;
      v = value;
      res = 64'd0;
      bitv = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // Entry k is 2^(-2^-k) in Q0.30, built by repeated square roots.
   function automatic logic [16:0][29:0] root_table_f();
      logic [16:0][29:0] tab;
      logic [63:0] r;
      r = 64'd1 << 29;
      tab[0] = r[29:0];
      for (int k = 1; k <= 16; k++) begin
         r = isqrt64(r << 30);
         tab[k] = r[29:0];
      end
      return tab;
   endfunction

   localparam logic [16:0][29:0] ROOTS = root_table_f();

endpackage
`default_nettype wire

// ----- design/mma_ram.sv -----
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered, valid in the cycle after the read address. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module mma_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     write_enable,
   input  wire logic [$clog2(DEPTH)-1:0] write_address,
   input  wire logic [WIDTH-1:0]         write_data,
   input  wire logic [$clog2(DEPTH)-1:0] read_address,
   output logic      [WIDTH-1:0]         read_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_address] <= write_data;
      end
      read_data <= mem[read_address];
   end
endmodule
`default_nettype wire

// ----- design/mma_div.sv -----
// Restoring divider, one quotient bit per cycle, 34 quotient bits.
// The dividend must be below divisor * 2^34. No package dependencies.
`timescale 1ns / 1ps
`default_nettype none
module mma_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] dividend,
   input  wire logic [30:0] divisor,
   output logic             done,
   output logic [33:0]      quotient,
   output logic [30:0]      remainder
);
   logic        busy_ff;
   logic        done_ff;
   logic [5:0]  cnt_ff;
   logic [30:0] r_ff;
   logic [33:0] d_ff;
   logic [30:0] dsr_ff;
   logic [31:0] r2;
   logic        ge;

   assign r2 = {r_ff, d_ff[33]};
   assign ge = r2 >= {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 6'd0;
            r_ff    <= {1'b0, dividend[63:34]};
            d_ff    <= dividend[33:0];
            dsr_ff  <= divisor;
         end else if (busy_ff) begin
            r_ff   <= ge ? 31'(r2 - {1'b0, dsr_ff}) : r2[30:0];
            d_ff   <= {d_ff[32:0], ge};
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd33) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = d_ff;
   assign remainder = r_ff;
endmodule
`default_nettype wire

// ----- design/mma_exp.sv -----
// Iterative evaluation of 2^(-dv * log2 e) as an acceptance probability in Q1.24.
// Uses the root table and constants of mma_pkg; one multiply per cycle.
`timescale 1ns / 1ps
`default_nettype none
module mma_exp (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [30:0] dv,
   output logic             done,
   output logic [24:0]      prob
);
   import mma_pkg::*;

   typedef enum logic [1:0] {E_IDLE, E_ROUND, E_LOOP, E_FINISH} state_type;

   state_type   state_ff;
   logic        done_ff;
   logic [61:0] prod_ff;
   logic [15:0] n_ff;
   logic [15:0] f_ff;
   logic [4:0]  k_ff;
   logic [30:0] a_ff;
   logic [24:0] prob_ff;
   logic [31:0] z;
   logic [60:0] step_prod;
   logic [30:0] a_shift;

   assign z         = 32'((prod_ff + 62'd536870912) >> 30);
   assign step_prod = a_ff * ROOTS[k_ff];
   assign a_shift   = (n_ff >= 16'd31) ? 31'd0 : (a_ff >> n_ff[4:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            E_IDLE: begin
               if (start) begin
                  prod_ff  <= dv * LOG2E_Q30;
                  state_ff <= E_ROUND;
               end
            end
            E_ROUND: begin
               n_ff     <= z[31:16];
               f_ff     <= z[15:0];
               a_ff     <= ONE_Q30;
               k_ff     <= 5'd1;
               state_ff <= E_LOOP;
            end
            E_LOOP: begin
               if (f_ff[15]) begin
                  a_ff <= step_prod[60:30];
               end
               f_ff <= {f_ff[14:0], 1'b0};
               k_ff <= k_ff + 5'd1;
               if (k_ff == 5'd16) begin
                  state_ff <= E_FINISH;
               end
            end
            E_FINISH: begin
               prob_ff  <= 25'(a_shift >> 6);
               done_ff  <= 1'b1;
               state_ff <= E_IDLE;
            end
            default: state_ff <= E_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign prob = prob_ff;
endmodule
`default_nettype wire

// ----- design/multicanonical_metropolis_accept.sv -----
// Multicanonical Metropolis acceptance with a table-interpolated bias potential.
// Items arrive on the req_ channel (valid/ready) and each gives one result
// item on the rsp_ channel. Command 0 writes a potential table entry, command 1
// sets the stored charge, command 2 proposes a charge change and decides it,
// and command 3 only reports the stored charge. Writes, charge loads and
// command 3 go from the idle state straight to the final state, which
// loads the output register. A proposal evaluates the potential at the old
// and the new charge, each through the serial divider, a serial multiply and
// the divider again; a positive change then runs the iterative exponential.
// A charge outside the grid takes the nearest edge entry without interpolating.
// One item is processed at a time; the next is taken once the finished
// result sits in the output register, even if the receiver has not taken it.
// A stalled receiver holds the result, and the block waits in its final
// state until the register frees. Reset clears the stored charge, restores
// the configuration defaults and empties the output; the potential table
// holds no defined contents until written. The user must write configuration
// on csr_write_enable only while the block is idle; this is not enforced.
`timescale 1ns / 1ps
`default_nettype none
module multicanonical_metropolis_accept #(
   parameter int TABLE_DEPTH = 1024,
   parameter int RANDOM_BITS = 24
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire mma_pkg::req_type req_item,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output mma_pkg::rsp_type      rsp_item,
   input  wire logic             csr_write_enable,
   input  wire logic [1:0]       csr_index,
   input  wire logic [30:0]      csr_write_data
);
   import mma_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);

   typedef enum logic [3:0] {
      S_IDLE, S_SETUP, S_DIVIDX, S_RDLO, S_CAPLO, S_CAPHI, S_MUL, S_DIVSTART,
      S_DIVFRAC, S_RDEDGE, S_CAPEDGE, S_EXPSTART, S_EXPWAIT, S_DECIDE, S_DONE
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      if (v > 34'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -34'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   state_type          state_ff;
   logic [30:0]        ghr_ff;
   logic [30:0]        sp_ff;
   logic [10:0]        pts_ff;
   logic signed [31:0] charge_ff;
   logic signed [31:0] qnew_ff;
   logic [23:0]        u_ff;
   logic               pt_sel_ff;
   logic [AW-1:0]      addr_ff;
   logic [30:0]        rem_ff;
   logic signed [31:0] lo_ff;
   logic               neg_ff;
   logic [63:0]        mag_ff;
   logic [63:0]        acc_ff;
   logic [4:0]         mcnt_ff;
   logic signed [31:0] vold_ff;
   logic signed [31:0] dv_ff;
   logic [24:0]        prob_ff;
   rsp_type            res_ff;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff;

   logic               req_fire;
   logic [30:0]        sp_eff;
   logic [31:0]        n_eff;
   logic [33:0]        nm1;
   logic signed [31:0] x;
   logic signed [33:0] t;
   logic               div_start;
   logic [63:0]        div_dividend;
   logic               div_done;
   logic [33:0]        div_q;
   logic [30:0]        div_r;
   logic               exp_start;
   logic               exp_done;
   logic [24:0]        exp_prob;
   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [31:0]        ram_rdata;
   logic signed [32:0] diff;
   logic signed [34:0] q_frac;
   logic signed [31:0] v_interp;
   logic [23:0]        u_mask;
   logic               reject;
   logic               slot_free;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign sp_eff = (sp_ff == 31'd0) ? 31'd1 : sp_ff;
   always_comb begin
      if (pts_ff < 11'd2) begin
         n_eff = 32'd2;
      end else if (32'(pts_ff) > 32'(TABLE_DEPTH)) begin
         n_eff = 32'(TABLE_DEPTH);
      end else begin
         n_eff = 32'(pts_ff);
      end
   end
   assign nm1 = 34'(n_eff - 32'd1);

   assign x = pt_sel_ff ? qnew_ff : charge_ff;
   assign t = 34'(x) + 34'(signed'({1'b0, ghr_ff}));

   assign div_start    = (state_ff == S_SETUP && !t[33]) || (state_ff == S_DIVSTART);
   assign div_dividend = (state_ff == S_SETUP) ? 64'(t[32:0]) : acc_ff;

   assign diff     = 33'(signed'(ram_rdata)) - 33'(lo_ff);
   assign q_frac   = neg_ff ? ((div_r != 31'd0) ? -35'(div_q) - 35'sd1 : -35'(div_q))
                            : 35'(div_q);
   assign v_interp = 32'(35'(lo_ff) + q_frac);

   assign exp_start = (state_ff == S_EXPSTART) && (dv_ff > 32'sd0);

   assign ram_we    = req_fire && req_item.cmd == CMD_WRITE
                      && 32'(req_item.table_index) < 32'(TABLE_DEPTH);
   assign ram_waddr = AW'(req_item.table_index);

   assign u_mask = 24'(({8'd0, u_ff}) & 32'((64'd1 << RANDOM_BITS) - 64'd1));
   assign reject = (64'(u_mask) << 24) > (64'(prob_ff) << RANDOM_BITS);

   mma_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_table (
      .clock         (clock),
      .write_enable  (ram_we),
      .write_address (ram_waddr),
      .write_data    (req_item.load_value),
      .read_address  (addr_ff),
      .read_data     (ram_rdata)
   );

   mma_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (sp_eff),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   mma_exp u_exp (
      .clock (clock),
      .reset (reset),
      .start (exp_start),
      .dv    (dv_ff[30:0]),
      .done  (exp_done),
      .prob  (exp_prob)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ghr_ff       <= 31'd1310720;
         sp_ff        <= 31'd65536;
         pts_ff       <= 11'd1024;
         charge_ff    <= 32'sd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_HALF_RANGE: ghr_ff <= csr_write_data;
               CSR_SPACING:    sp_ff  <= csr_write_data;
               CSR_POINTS:     pts_ff <= csr_write_data[10:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  res_ff.accepted           <= 1'b0;
                  res_ff.potential_change   <= 32'sd0;
                  res_ff.accept_probability <= 25'd0;
                  case (req_item.cmd)
                     CMD_CHARGE: begin
                        charge_ff         <= req_item.load_value;
                        res_ff.charge_now <= req_item.load_value;
                        state_ff          <= S_DONE;
                     end
                     CMD_PROPOSE: begin
                        qnew_ff   <= sat32(34'(charge_ff) + 34'(req_item.charge_delta));
                        u_ff      <= req_item.uniform_fraction;
                        pt_sel_ff <= 1'b0;
                        state_ff  <= S_SETUP;
                     end
                     default: begin
                        res_ff.charge_now <= charge_ff;
                        state_ff          <= S_DONE;
                     end
                  endcase
               end
            end
            S_SETUP: begin
               if (t[33]) begin
                  addr_ff  <= '0;
                  state_ff <= S_RDEDGE;
               end else begin
                  state_ff <= S_DIVIDX;
               end
            end
            S_DIVIDX: begin
               if (div_done) begin
                  if (div_q >= nm1) begin
                     addr_ff  <= AW'(nm1);
                     state_ff <= S_RDEDGE;
                  end else begin
                     addr_ff  <= AW'(div_q);
                     rem_ff   <= div_r;
                     state_ff <= S_RDLO;
                  end
               end
            end
            S_RDLO: begin
               addr_ff  <= addr_ff + AW'(1);
               state_ff <= S_CAPLO;
            end
            S_CAPLO: begin
               lo_ff    <= ram_rdata;
               state_ff <= S_CAPHI;
            end
            S_CAPHI: begin
               neg_ff   <= diff[32];
               mag_ff   <= 64'(diff[32] ? 33'(-diff) : 33'(diff));
               acc_ff   <= 64'd0;
               mcnt_ff  <= 5'd0;
               state_ff <= S_MUL;
            end
            S_MUL: begin
               if (rem_ff[0]) begin
                  acc_ff <= acc_ff + mag_ff;
               end
               mag_ff  <= mag_ff << 1;
               rem_ff  <= rem_ff >> 1;
               mcnt_ff <= mcnt_ff + 5'd1;
               if (mcnt_ff == 5'd30) begin
                  state_ff <= S_DIVSTART;
               end
            end
            S_DIVSTART: begin
               state_ff <= S_DIVFRAC;
            end
            S_DIVFRAC: begin
               if (div_done) begin
                  if (!pt_sel_ff) begin
                     vold_ff   <= v_interp;
                     pt_sel_ff <= 1'b1;
                     state_ff  <= S_SETUP;
                  end else begin
                     dv_ff    <= sat32(34'(v_interp) - 34'(vold_ff));
                     state_ff <= S_EXPSTART;
                  end
               end
            end
            S_RDEDGE: begin
               state_ff <= S_CAPEDGE;
            end
            S_CAPEDGE: begin
               if (!pt_sel_ff) begin
                  vold_ff   <= ram_rdata;
                  pt_sel_ff <= 1'b1;
                  state_ff  <= S_SETUP;
               end else begin
                  dv_ff    <= sat32(34'(signed'(ram_rdata)) - 34'(vold_ff));
                  state_ff <= S_EXPSTART;
               end
            end
            S_EXPSTART: begin
               if (dv_ff > 32'sd0) begin
                  state_ff <= S_EXPWAIT;
               end else begin
                  prob_ff  <= ONE_Q24;
                  state_ff <= S_DECIDE;
               end
            end
            S_EXPWAIT: begin
               if (exp_done) begin
                  prob_ff  <= exp_prob;
                  state_ff <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               res_ff.accepted           <= !reject;
               res_ff.potential_change   <= dv_ff;
               res_ff.accept_probability <= prob_ff;
               res_ff.charge_now         <= reject ? charge_ff : qnew_ff;
               if (!reject) begin
                  charge_ff <= qnew_ff;
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (slot_free) begin
                  rsp_ff       <= res_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;
endmodule
`default_nettype wire

// ----- tb/sv/multicanonical_metropolis_accept_tb.sv -----
// Self-checking testbench for the multicanonical Metropolis acceptance block.
// A scoreboard class predicts every result from the accepted items; it depends on mma_pkg
// and on the multicanonical_metropolis_accept module.
`timescale 1ns / 1ps
module multicanonical_metropolis_accept_tb;
   import mma_pkg::*;

   class charge_scoreboard;
      int                pot [1024];
      int                charge;
      longint            half_range;
      longint            spacing;
      longint            points;
      longint unsigned   roots [17];
      rsp_type           expected [$];
      int                mismatches;

      function new();
         longint unsigned lo, hi, mid, v;
         foreach (pot[i]) pot[i] = 0;
         charge = 0;
         half_range = 1310720;
         spacing = 65536;
         points = 1024;
         mismatches = 0;
         roots[0] = 64'd1 << 29;
         for (int k = 1; k <= 16; k++) begin
            v = roots[k - 1] << 30;
            lo = 0;
            hi = 64'd1 << 31;
            while (hi - lo > 1) begin
               mid = (lo + hi) >> 1;
               if (mid * mid <= v) lo = mid;
               else hi = mid;
            end
            roots[k] = lo;
         end
      endfunction

      function void set_reg(logic [1:0] idx, logic [30:0] data);
         case (idx)
            CSR_HALF_RANGE: half_range = longint'(data);
            CSR_SPACING:    spacing = longint'(data);
            CSR_POINTS:     points = longint'(data[10:0]);
            default: ;
         endcase
      endfunction

      function longint sat32(longint v);
         if (v > 64'sd2147483647) return 64'sd2147483647;
         if (v < -64'sd2147483648) return -64'sd2147483648;
         return v;
      endfunction

      function longint potential_at(longint x);
         longint n, sp, t, idx, rem, lo, hi, prod, q;
         n = points;
         if (n < 2) n = 2;
         if (n > 1024) n = 1024;
         sp = (spacing == 0) ? 1 : spacing;
         t = x + half_range;
         if (t < 0) return pot[0];
         idx = t / sp;
         if (idx >= n - 1) return pot[n - 1];
         rem = t - idx * sp;
         lo = pot[idx];
         hi = pot[idx + 1];
         prod = (hi - lo) * rem;
         q = prod / sp;
         if (prod < 0 && q * sp != prod) q = q - 1;
         return lo + q;
      endfunction

      function longint unsigned probability(longint dv);
         longint unsigned z, n, f, a;
         if (dv <= 0) return 64'd1 << 24;
         z = (longint'(dv) * 64'd1549082005 + (64'd1 << 29)) >> 30;
         n = z >> 16;
         f = z & 64'hFFFF;
         a = 64'd1 << 30;
         for (int k = 1; k <= 16; k++)
            if (f[16 - k]) a = (a * roots[k]) >> 30;
         if (n >= 31) a = 0;
         else a = a >> n;
         return a >> 6;
      endfunction

      function void note_request(req_type r);
         rsp_type e;
         longint q_old, q_new, dv;
         longint unsigned p;
         e = '0;
         if (r.cmd == CMD_WRITE) begin
            pot[r.table_index] = r.load_value;
         end else if (r.cmd == CMD_CHARGE) begin
            charge = r.load_value;
         end else if (r.cmd == CMD_PROPOSE) begin
            q_old = charge;
            q_new = sat32(q_old + longint'(r.charge_delta));
            dv = sat32(potential_at(q_new) - potential_at(q_old));
            p = probability(dv);
            e.potential_change = 32'(dv);
            e.accept_probability = 25'(p);
            if (longint'(r.uniform_fraction) <= p) begin
               e.accepted = 1'b1;
               charge = 32'(q_new);
            end
         end
         e.charge_now = charge;
         expected.push_back(e);
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result item %p", got);
            return;
         end
         e = expected.pop_front();
         if (got.accepted !== e.accepted || got.charge_now !== e.charge_now ||
             got.potential_change !== e.potential_change ||
             got.accept_probability !== e.accept_probability) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"Mismatch: expected acc %0d q %0d dv %0d p %0d, ",
                         "got acc %0d q %0d dv %0d p %0d"},
                        e.accepted, e.charge_now, e.potential_change, e.accept_probability,
                        got.accepted, got.charge_now, got.potential_change,
                        got.accept_probability);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_item = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_item;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = CSR_HALF_RANGE;
   logic [30:0] csr_write_data = '0;

   charge_scoreboard sb = new();
   int burst_left = 0;
   int rx_left = 0;
   int rx_mode = 0;

   multicanonical_metropolis_accept dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_item(rsp_item),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #100ms;
      $display("simulation failed");
      $finish;
   end

   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode = $urandom_range(0, 3);
         rx_left = $urandom_range(5, 60);
      end
      rx_left--;
      case (rx_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= ($urandom_range(0, 7) == 0);
         default: rsp_ready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_item);
   end

   task automatic issue_item(input req_type r);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 30);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (!req_ready);
      sb.note_request(r);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.expected.size() > 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [30:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      sb.set_reg(idx, data);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic req_type make_item(logic [1:0] cmd, logic [9:0] idx,
                                         logic [31:0] load, logic [31:0] delta,
                                         logic [23:0] u);
      req_type r;
      r.cmd = cmd;
      r.table_index = idx;
      r.load_value = load;
      r.charge_delta = delta;
      r.uniform_fraction = u;
      return r;
   endfunction

   function automatic longint rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [31:0] grid_charge();
      longint sp, n, span;
      sp = (sb.spacing == 0) ? 1 : sb.spacing;
      n = (sb.points < 2) ? 2 : ((sb.points > 1024) ? 1024 : sb.points);
      span = n * sp + 2 * sp;
      return 32'(sb.sat32(-sb.half_range - sp + longint'(unsigned'(rand64()) % span)));
   endfunction

   function automatic req_type random_item();
      int pick;
      logic [31:0] v, d;
      longint sp;
      pick = $urandom_range(0, 99);
      sp = (sb.spacing == 0) ? 1 : sb.spacing;
      if (pick < 12) begin
         v = ($urandom_range(0, 9) == 0) ? $urandom : $signed($urandom_range(0, 786432)) - 393216;
         return make_item(CMD_WRITE, 10'($urandom), v, $urandom, 24'($urandom));
      end
      if (pick < 22) begin
         v = ($urandom_range(0, 4) == 0) ? $urandom : grid_charge();
         return make_item(CMD_CHARGE, 10'($urandom), v, $urandom, 24'($urandom));
      end
      if (pick < 25) return make_item(2'd3, 10'($urandom), $urandom, $urandom, 24'($urandom));
      if ($urandom_range(0, 7) == 0) d = $urandom;
      else d = 32'(sb.sat32(longint'(unsigned'(rand64()) % (8 * sp + 1)) - 4 * sp));
      return make_item(CMD_PROPOSE, 10'($urandom), $urandom, d, 24'($urandom));
   endfunction

   initial begin
      // Every phase reads only the filled entries: the wide-spacing phase
      // reaches the lowest few entries alone.
      logic [30:0] phase_half [6] = '{31'd1310720, 31'd0, 31'h7FFFFFFF, 31'd655360,
                                      31'd3276800, 31'd1310720};
      logic [30:0] phase_spacing [6] = '{31'd65536, 31'd1, 31'h7FFFFFFF, 31'd0,
                                         31'd6553, 31'd65536};
      logic [30:0] phase_points [6] = '{31'd256, 31'd2, 31'd2047, 31'd1, 31'd100, 31'd256};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Every table entry that a proposal can read is defined first.
      for (int i = 0; i < 256; i++)
         issue_item(make_item(CMD_WRITE, 10'(i), $signed($urandom_range(0, 786432)) - 393216,
                              $urandom, 24'($urandom)));

      issue_item(make_item(2'd3, 10'h3FF, 32'hFFFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF));
      issue_item(make_item(CMD_WRITE, 10'd0, 32'h80000000, 32'd0, 24'd0));
      issue_item(make_item(CMD_WRITE, 10'd1023, 32'h7FFFFFFF, 32'd0, 24'd0));
      issue_item(make_item(CMD_CHARGE, 10'd0, 32'h80000000, 32'd0, 24'd0));
      issue_item(make_item(CMD_PROPOSE, 10'd0, 32'd0, 32'h7FFFFFFF, 24'd0));
      issue_item(make_item(CMD_CHARGE, 10'd0, 32'h80000000, 32'd0, 24'd0));
      issue_item(make_item(CMD_PROPOSE, 10'd0, 32'd0, 32'h7FFFFFFF, 24'hFFFFFF));
      issue_item(make_item(CMD_PROPOSE, 10'd0, 32'd0, 32'h80000000, 24'd1));
      issue_item(make_item(CMD_CHARGE, 10'd0, 32'h7FFFFFFF, 32'd0, 24'd0));
      issue_item(make_item(CMD_PROPOSE, 10'd0, 32'd0, 32'h7FFFFFFF, 24'hFFFFFF));
      issue_item(make_item(CMD_PROPOSE, 10'd0, 32'd0, 32'h80000000, 24'hFFFFFF));
      issue_item(make_item(CMD_CHARGE, 10'd0, 32'd0, 32'd0, 24'd0));
      issue_item(make_item(CMD_PROPOSE, 10'd0, 32'd0, 32'd0, 24'hFFFFFF));
      issue_item(make_item(CMD_PROPOSE, 10'd0, 32'd0, 32'd65536, 24'h800000));
      issue_item(make_item(CMD_PROPOSE, 10'd0, 32'd0, 32'hFFFF0000, 24'h000001));
      issue_item(make_item(CMD_WRITE, 10'd0, $signed($urandom_range(0, 65536)), 32'd0, 24'd0));
      issue_item(make_item(CMD_WRITE, 10'd1023, $signed($urandom_range(0, 65536)), 32'd0, 24'd0));

      for (int ph = 0; ph < 6; ph++) begin
         wait_drained();
         write_reg(CSR_HALF_RANGE, phase_half[ph]);
         write_reg(CSR_SPACING, phase_spacing[ph]);
         write_reg(CSR_POINTS, phase_points[ph]);
         for (int i = 0; i < 112; i++) issue_item(random_item());
      end

      wait_drained();
      repeat (300) @(negedge clock);
      if (sb.mismatches == 0 && sb.expected.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
